// File: src/tsfp_pkg.sv
package tsfp_pkg;

  // Field labels carried with every byte
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_TAG       = 3'd1,
    KIND_LENGTH    = 3'd2,
    KIND_DEVID     = 3'd3,
    KIND_TIME      = 3'd4,
    KIND_TEMP_INT  = 3'd5,
    KIND_TEMP_FRAC = 3'd6,
    KIND_CRC       = 3'd7
  } kind_t;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_OK      = 3'd1,
    ST_BAD_HDR = 3'd2,
    ST_BAD_TAG = 3'd3,
    ST_BAD_LEN = 3'd4,
    ST_BAD_CRC = 3'd5,
    ST_IGNORED = 3'd6
  } status_t;

  // Register indexes, taken from paddr[2]
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAG    = 1'b1;

  localparam int unsigned IDX_W  = 5;
  localparam int unsigned TEMP_W = 15;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_MSB     = 16'h8000;
  localparam logic [TEMP_W-1:0] TEMP_SCALE = 15'd100;

  localparam logic [7:0] TAG_RESET = 8'h01;

  // One result word, parser to output register
  typedef struct packed {
    kind_t             field_kind;
    logic [IDX_W-1:0]  field_byte_index;
    logic [7:0]        data_out;
    logic              frame_done;
    status_t           status;
    logic [TEMP_W-1:0] temperature_hundredths;
  } result_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/tlv_sensor_frame_parser.sv
// Channel | Handshake          | Payload
// input   | in_valid, in_stall | byte_in, frame_start
// output  | out_valid, out_stall | field_kind, field_byte_index, data_out,
//         |                    | frame_done, status, temperature_hundredths
// config  | APB write/read     | paddr, pwdata, prdata (expected_header, expected_tag)
//
// One byte per cycle sustained while out_stall is low; each word passes through
// the input register, then the result register.
// The CRC-16 byte update and field decode are combinational between the two registers.
// Synchronous active-high reset: parser idle, CRC at 0xFFFF, tag register 0x01.
// out_stall holds the result register and, through in_stall, the input register.
module tlv_sensor_frame_parser #(
  parameter int unsigned DEVICE_ID_BYTES = 8,
  parameter int unsigned TIME_TEXT_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  field_kind,
  output logic [4:0]  field_byte_index,
  output logic [7:0]  data_out,
  output logic        frame_done,
  output logic [2:0]  status,
  output logic [14:0] temperature_hundredths,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               advance;
  logic               step;
  logic               in_q_valid;
  logic [7:0]         byte_q;
  logic               start_q;
  logic [15:0]        expected_header;
  logic [7:0]         expected_tag;
  tsfp_pkg::result_t  res;
  tsfp_pkg::result_t  out_q;

  // Pipeline moves whenever the result register is free or drained
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign step     = advance && in_q_valid;

  tsfp_cfg_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .expected_header (expected_header),
    .expected_tag    (expected_tag)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (advance) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      byte_q  <= byte_in;
      start_q <= frame_start;
    end
  end

  tsfp_field_parser #(
    .DEVICE_ID_BYTES (DEVICE_ID_BYTES),
    .TIME_TEXT_BYTES (TIME_TEXT_BYTES)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .byte_q          (byte_q),
    .start_q         (start_q),
    .expected_header (expected_header),
    .expected_tag    (expected_tag),
    .res             (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign field_kind             = out_q.field_kind;
  assign field_byte_index       = out_q.field_byte_index;
  assign data_out               = out_q.data_out;
  assign frame_done             = out_q.frame_done;
  assign status                 = out_q.status;
  assign temperature_hundredths = out_q.temperature_hundredths;

`ifndef SYNTHESIS
  a_word_moves: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("parsed word did not reach result register");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(in_q_valid))
    else $error("input register moved while output stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    advance && !in_q_valid |=> !out_valid)
    else $error("result word without input word");
`endif

endmodule

// File: src/tsfp_cfg_regs.sv
module tsfp_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] expected_header,
  output logic [7:0]  expected_tag
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_header <= 16'h0000;
      expected_tag    <= tsfp_pkg::TAG_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        tsfp_pkg::REG_HEADER: expected_header <= pwdata[15:0];
        tsfp_pkg::REG_TAG:    expected_tag    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      tsfp_pkg::REG_HEADER: prdata = {16'h0000, expected_header};
      tsfp_pkg::REG_TAG:    prdata = {24'h000000, expected_tag};
      default:              prdata = 32'h0000_0000;
    endcase
  end

endmodule

// File: src/tsfp_field_parser.sv
module tsfp_field_parser #(
  parameter int unsigned DEVICE_ID_BYTES = 8,
  parameter int unsigned TIME_TEXT_BYTES = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_q,
  input  logic                start_q,
  input  logic [15:0]         expected_header,
  input  logic [7:0]          expected_tag,
  output tsfp_pkg::result_t   res
);

  localparam int unsigned OFF_DEV   = 5;
  localparam int unsigned OFF_TIME  = OFF_DEV + DEVICE_ID_BYTES;
  localparam int unsigned OFF_TINT  = OFF_TIME + TIME_TEXT_BYTES;
  localparam int unsigned OFF_TFRAC = OFF_TINT + 1;
  localparam int unsigned OFF_CRC   = OFF_TFRAC + 1;
  localparam int unsigned POS_W     = $clog2(OFF_CRC + 2);
  localparam logic [15:0] LEN_EXPECTED = 16'(DEVICE_ID_BYTES + TIME_TEXT_BYTES + 2);
  localparam int unsigned TEMP_W_L  = tsfp_pkg::TEMP_W;

  localparam logic [POS_W-1:0] P_HDR1  = POS_W'(1);
  localparam logic [POS_W-1:0] P_TAG   = POS_W'(2);
  localparam logic [POS_W-1:0] P_LEN0  = POS_W'(3);
  localparam logic [POS_W-1:0] P_LEN1  = POS_W'(4);
  localparam logic [POS_W-1:0] P_DEV   = POS_W'(OFF_DEV);
  localparam logic [POS_W-1:0] P_TIME  = POS_W'(OFF_TIME);
  localparam logic [POS_W-1:0] P_TLAST = POS_W'(OFF_TINT - 1);
  localparam logic [POS_W-1:0] P_TINT  = POS_W'(OFF_TINT);
  localparam logic [POS_W-1:0] P_TFRAC = POS_W'(OFF_TFRAC);
  localparam logic [POS_W-1:0] P_CRC   = POS_W'(OFF_CRC);
  localparam logic [POS_W-1:0] P_CRC1  = POS_W'(OFF_CRC + 1);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             in_frame, in_frame_next;
  logic [15:0]      crc_accumulator, crc_accumulator_next;
  logic [7:0]       held_high_byte, held_high_byte_next;
  logic [7:0]       temperature_integer, temperature_integer_next;
  logic [7:0]       temperature_frac, temperature_frac_next;

  logic [POS_W-1:0] pos;
  logic [15:0]      crc_cur;
  logic [15:0]      crc_upd;
  logic [7:0]       held_cur;
  logic             active;
  logic [TEMP_W_L-1:0] temp_calc;

  // Start marker restarts the frame at this byte
  assign pos      = start_q ? '0 : byte_position;
  assign crc_cur  = start_q ? tsfp_pkg::CRC_INIT : crc_accumulator;
  assign held_cur = start_q ? 8'h00 : held_high_byte;
  assign active   = start_q || in_frame;
  assign crc_upd  = tsfp_pkg::crc16_byte(crc_cur, byte_q);
  assign temp_calc = TEMP_W_L'(temperature_integer) * tsfp_pkg::TEMP_SCALE
                   + TEMP_W_L'(temperature_frac);

  // Label the byte, run the checks, update the frame state
  always_comb begin
    res                      = '0;
    res.status               = tsfp_pkg::ST_RUN;
    res.data_out             = byte_q;
    byte_position_next       = byte_position;
    in_frame_next            = in_frame;
    crc_accumulator_next     = crc_accumulator;
    held_high_byte_next      = held_high_byte;
    temperature_integer_next = start_q ? 8'h00 : temperature_integer;
    temperature_frac_next    = start_q ? 8'h00 : temperature_frac;

    if (!active) begin
      res.data_out = 8'h00;
      res.status   = tsfp_pkg::ST_IGNORED;
    end else begin
      in_frame_next        = 1'b1;
      held_high_byte_next  = held_cur;
      crc_accumulator_next = (pos < P_CRC) ? crc_upd : crc_cur;

      if (pos < P_TAG) begin
        res.field_kind       = tsfp_pkg::KIND_HEADER;
        res.field_byte_index = tsfp_pkg::IDX_W'(pos);
        held_high_byte_next  = byte_q;
        if (pos == P_HDR1 && {held_cur, byte_q} != expected_header) begin
          res.status     = tsfp_pkg::ST_BAD_HDR;
          res.frame_done = 1'b1;
        end
      end else if (pos == P_TAG) begin
        res.field_kind = tsfp_pkg::KIND_TAG;
        if (byte_q != expected_tag) begin
          res.status     = tsfp_pkg::ST_BAD_TAG;
          res.frame_done = 1'b1;
        end
      end else if (pos < P_DEV) begin
        res.field_kind       = tsfp_pkg::KIND_LENGTH;
        res.field_byte_index = tsfp_pkg::IDX_W'(pos - P_LEN0);
        held_high_byte_next  = byte_q;
        if (pos == P_LEN1 && {held_cur, byte_q} != LEN_EXPECTED) begin
          res.status     = tsfp_pkg::ST_BAD_LEN;
          res.frame_done = 1'b1;
        end
      end else if (pos < P_TIME) begin
        res.field_kind       = tsfp_pkg::KIND_DEVID;
        res.field_byte_index = tsfp_pkg::IDX_W'(pos - P_DEV);
      end else if (pos < P_TINT) begin
        res.field_kind       = tsfp_pkg::KIND_TIME;
        res.field_byte_index = tsfp_pkg::IDX_W'(pos - P_TIME);
        if (pos == P_TLAST) begin
          res.data_out = 8'h00;
        end
      end else if (pos == P_TINT) begin
        res.field_kind           = tsfp_pkg::KIND_TEMP_INT;
        temperature_integer_next = byte_q;
      end else if (pos == P_TFRAC) begin
        res.field_kind      = tsfp_pkg::KIND_TEMP_FRAC;
        held_high_byte_next = byte_q;
      end else begin
        res.field_kind       = tsfp_pkg::KIND_CRC;
        res.field_byte_index = tsfp_pkg::IDX_W'(pos - P_CRC);
        held_high_byte_next  = byte_q;
        if (pos == P_CRC) begin
          // fraction byte moves out of the holding register
          temperature_frac_next = held_cur;
        end else begin
          res.frame_done = 1'b1;
          if ({held_cur, byte_q} != crc_cur) begin
            res.status = tsfp_pkg::ST_BAD_CRC;
          end else begin
            res.status                 = tsfp_pkg::ST_OK;
            res.temperature_hundredths = temp_calc;
          end
        end
      end

      // Go idle after a done word
      if (res.frame_done) begin
        in_frame_next      = 1'b0;
        byte_position_next = '0;
      end else begin
        byte_position_next = pos + POS_W'(1);
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      in_frame            <= 1'b0;
      crc_accumulator     <= tsfp_pkg::CRC_INIT;
      held_high_byte      <= 8'h00;
      temperature_integer <= 8'h00;
      temperature_frac    <= 8'h00;
    end else if (step) begin
      byte_position       <= byte_position_next;
      in_frame            <= in_frame_next;
      crc_accumulator     <= crc_accumulator_next;
      held_high_byte      <= held_high_byte_next;
      temperature_integer <= temperature_integer_next;
      temperature_frac    <= temperature_frac_next;
    end
  end

`ifndef SYNTHESIS
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.frame_done |=> !in_frame && byte_position == '0)
    else $error("parser still in frame after done word");

  a_running_stays: assert property (@(posedge clk) disable iff (rst)
    step && !res.frame_done && res.status == tsfp_pkg::ST_RUN |=> in_frame)
    else $error("parser left frame without done word");

  a_ok_on_crc: assert property (@(posedge clk) disable iff (rst)
    res.status == tsfp_pkg::ST_OK |-> res.field_kind == tsfp_pkg::KIND_CRC && res.frame_done)
    else $error("ok status outside last crc byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> byte_position <= P_CRC1)
    else $error("byte position past end of frame");
`endif

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEV_BYTES   = 8;
  localparam int unsigned TIME_BYTES  = 20;
  localparam int unsigned OFF_DEV     = 5;
  localparam int unsigned OFF_TIME    = OFF_DEV + DEV_BYTES;
  localparam int unsigned OFF_TINT    = OFF_TIME + TIME_BYTES;
  localparam int unsigned OFF_TFRAC   = OFF_TINT + 1;
  localparam int unsigned OFF_CRC     = OFF_TFRAC + 1;
  localparam int unsigned FRAME_BYTES = OFF_CRC + 2;
  localparam logic [15:0] LEN_VALUE   = 16'(DEV_BYTES + TIME_BYTES + 2);
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Kinds of frame the stimulus builds
  typedef enum int {
    FR_GOOD,
    FR_BAD_HEADER,
    FR_BAD_TAG,
    FR_BAD_LENGTH,
    FR_BAD_CRC,
    FR_ABORT
  } frame_case_t;

  // Directed words: {frame_start, byte_in}
  localparam logic [8:0] DIRECTED_WORDS [24] = '{
    9'h0FF, 9'h000,                          // idle bytes, ignored
    9'h112, 9'h034,                          // header mismatch
    9'h100, 9'h000, 9'h0FE,                  // tag mismatch
    9'h100, 9'h000, 9'h001, 9'h0FF, 9'h0FF,  // length mismatch, all ones
    9'h100, 9'h000, 9'h001,                  // dropped by the next start
    9'h100, 9'h000, 9'h001, 9'h000, 9'h01E, 9'h0AB,
    9'h1FF, 9'h000,                          // restart inside device id
    9'h080                                   // idle byte after the frame ends
  };

  // Frame parser predictor and result checker
  class frame_tracker;
    tsfp_pkg::result_t expected_words[$];
    int unsigned errors;
    logic [15:0] header_reg;
    logic [7:0]  tag_reg;
    bit          in_frame;
    int unsigned pos;
    logic [15:0] crc;
    logic [7:0]  high_byte;
    logic [7:0]  int_byte;
    logic [7:0]  frac_byte;

    function new();
      errors     = 0;
      header_reg = 16'h0000;
      tag_reg    = tsfp_pkg::TAG_RESET;
      in_frame   = 1'b0;
      pos        = 0;
      crc        = tsfp_pkg::CRC_INIT;
      high_byte  = 8'h00;
      int_byte   = 8'h00;
      frac_byte  = 8'h00;
    endfunction

    // CRC-16, poly 0x1021, MSB first
    static function logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void set_register(input logic sel, input logic [15:0] value);
      if (sel == tsfp_pkg::REG_HEADER) begin
        header_reg = value;
      end else begin
        tag_reg = value[7:0];
      end
    endfunction

    // Advance the parser by one accepted byte and queue its result word
    function void take_byte(input logic [7:0] b, input logic start);
      tsfp_pkg::result_t r;
      int unsigned p;
      logic [15:0] rx;
      r = '0;
      if (start) begin
        in_frame  = 1'b1;
        pos       = 0;
        crc       = tsfp_pkg::CRC_INIT;
        high_byte = 8'h00;
        int_byte  = 8'h00;
      end
      if (!in_frame) begin
        r.status = tsfp_pkg::ST_IGNORED;
        expected_words.push_back(r);
        return;
      end
      p = pos;
      r.data_out = b;
      r.status   = tsfp_pkg::ST_RUN;
      if (p < OFF_CRC) crc = crc_next(crc, b);
      if (p < 2) begin
        r.field_kind       = tsfp_pkg::KIND_HEADER;
        r.field_byte_index = 5'(p);
        if (p == 1 && {high_byte, b} != header_reg) begin
          r.status     = tsfp_pkg::ST_BAD_HDR;
          r.frame_done = 1'b1;
        end
      end else if (p == 2) begin
        r.field_kind = tsfp_pkg::KIND_TAG;
        if (b != tag_reg) begin
          r.status     = tsfp_pkg::ST_BAD_TAG;
          r.frame_done = 1'b1;
        end
      end else if (p < OFF_DEV) begin
        r.field_kind       = tsfp_pkg::KIND_LENGTH;
        r.field_byte_index = 5'(p - 3);
        if (p == 4 && {high_byte, b} != LEN_VALUE) begin
          r.status     = tsfp_pkg::ST_BAD_LEN;
          r.frame_done = 1'b1;
        end
      end else if (p < OFF_TIME) begin
        r.field_kind       = tsfp_pkg::KIND_DEVID;
        r.field_byte_index = 5'(p - OFF_DEV);
      end else if (p < OFF_TINT) begin
        r.field_kind       = tsfp_pkg::KIND_TIME;
        r.field_byte_index = 5'(p - OFF_TIME);
        // last time byte goes out as zero, CRC still takes the raw byte
        if (p == OFF_TINT - 1) r.data_out = 8'h00;
      end else if (p == OFF_TINT) begin
        r.field_kind = tsfp_pkg::KIND_TEMP_INT;
        int_byte     = b;
      end else if (p == OFF_TFRAC) begin
        r.field_kind = tsfp_pkg::KIND_TEMP_FRAC;
        frac_byte    = b;
      end else begin
        r.field_kind       = tsfp_pkg::KIND_CRC;
        r.field_byte_index = 5'(p - OFF_CRC);
        if (p == OFF_CRC + 1) begin
          rx           = {high_byte, b};
          r.frame_done = 1'b1;
          if (rx != crc) begin
            r.status = tsfp_pkg::ST_BAD_CRC;
          end else begin
            r.status                 = tsfp_pkg::ST_OK;
            r.temperature_hundredths = 15'(int_byte * 100 + frac_byte);
          end
        end
      end
      // hold the first byte of each two-byte field
      if (p < 2 || p == 3 || p == 4 || p == OFF_CRC) high_byte = b;
      if (r.frame_done) begin
        in_frame = 1'b0;
        pos      = 0;
      end else begin
        pos = p + 1;
      end
      expected_words.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    // Compare one accepted result word against the oldest expectation
    function void check_word(input tsfp_pkg::result_t seen);
      tsfp_pkg::result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("field_kind", 16'(want.field_kind), 16'(seen.field_kind));
      compare_field("field_byte_index", 16'(want.field_byte_index),
                    16'(seen.field_byte_index));
      compare_field("data_out", 16'(want.data_out), 16'(seen.data_out));
      compare_field("frame_done", 16'(want.frame_done), 16'(seen.frame_done));
      compare_field("status", 16'(want.status), 16'(seen.status));
      compare_field("temperature_hundredths", 16'(want.temperature_hundredths),
                    16'(seen.temperature_hundredths));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  field_kind;
  logic [4:0]  field_byte_index;
  logic [7:0]  data_out;
  logic        frame_done;
  logic [2:0]  status;
  logic [14:0] temperature_hundredths;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'b000;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker sb = new();
  bit          quiet = 1'b0;
  int unsigned idle_pct = 20;
  int unsigned stall_pct = 10;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  tlv_sensor_frame_parser #(
    .DEVICE_ID_BYTES(DEV_BYTES),
    .TIME_TEXT_BYTES(TIME_BYTES)
  ) u_dut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .byte_in                (byte_in),
    .frame_start            (frame_start),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .field_kind             (field_kind),
    .field_byte_index       (field_byte_index),
    .data_out               (data_out),
    .frame_done             (frame_done),
    .status                 (status),
    .temperature_hundredths (temperature_hundredths),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check accepted result words and drive random stall bursts
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && !out_stall) begin
      sb.check_word({field_kind, field_byte_index, data_out, frame_done, status,
                     temperature_hundredths});
    end
    if (cycle_count % 128 == 0) stall_pct = 8 * $urandom_range(0, 3);
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one word and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic start);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    byte_in     <= b;
    frame_start <= start;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b, start);
  endtask

  // Stop sending and wait for every expected word
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(sel, value);
  endtask

  // Build one frame with random content, break it as asked, and send it
  task automatic send_frame(input frame_case_t mode, output int unsigned used);
    logic [7:0]  f [FRAME_BYTES];
    logic [15:0] c;
    logic [15:0] len;
    int unsigned n;
    int unsigned at;
    f[0] = sb.header_reg[15:8];
    f[1] = sb.header_reg[7:0];
    f[2] = sb.tag_reg;
    f[3] = LEN_VALUE[15:8];
    f[4] = LEN_VALUE[7:0];
    for (int i = OFF_DEV; i < OFF_TINT; i++) f[i] = 8'($urandom_range(0, 255));
    f[OFF_TINT]  = ($urandom_range(0, 7) == 0) ? {8{1'($urandom_range(0, 1))}}
                                                : 8'($urandom_range(0, 255));
    f[OFF_TFRAC] = ($urandom_range(0, 7) == 0) ? {8{1'($urandom_range(0, 1))}}
                                                : 8'($urandom_range(0, 255));
    c = tsfp_pkg::CRC_INIT;
    for (int i = 0; i < OFF_CRC; i++) c = frame_tracker::crc_next(c, f[i]);
    f[OFF_CRC]     = c[15:8];
    f[OFF_CRC + 1] = c[7:0];
    n = FRAME_BYTES;
    case (mode)
      FR_BAD_HEADER: begin
        at    = $urandom_range(0, 1);
        f[at] = f[at] ^ 8'($urandom_range(1, 255));
        n     = 2;
      end
      FR_BAD_TAG: begin
        f[2] = f[2] ^ 8'($urandom_range(1, 255));
        n    = 3;
      end
      FR_BAD_LENGTH: begin
        case ($urandom_range(0, 3))
          0: len = 16'h0000;
          1: len = 16'hFFFF;
          default: len = 16'($urandom_range(0, 65535));
        endcase
        if (len == LEN_VALUE) len = len ^ 16'h0100;
        f[3] = len[15:8];
        f[4] = len[7:0];
        n    = 5;
      end
      FR_BAD_CRC: begin
        at    = $urandom_range(OFF_DEV, FRAME_BYTES - 1);
        f[at] = f[at] ^ 8'(1 << $urandom_range(0, 7));
      end
      FR_ABORT: begin
        n = $urandom_range(1, FRAME_BYTES - 1);
      end
      default: begin
      end
    endcase
    for (int unsigned i = 0; i < n; i++) send_word(f[i], i == 0);
    used = n;
    // trail some idle bytes after a finished frame
    if (mode != FR_ABORT && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic run_frames(input int unsigned target);
    int unsigned sent;
    int unsigned used;
    int unsigned pick;
    frame_case_t mode;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      mode = FR_GOOD;
      else if (pick < 68) mode = FR_BAD_HEADER;
      else if (pick < 74) mode = FR_BAD_TAG;
      else if (pick < 80) mode = FR_BAD_LENGTH;
      else if (pick < 90) mode = FR_BAD_CRC;
      else                mode = FR_ABORT;
      idle_pct = 15 * $urandom_range(0, 2);
      send_frame(mode, used);
      sent += used;
    end
  endtask

  // Main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 24; i++) begin
      send_word(DIRECTED_WORDS[i][7:0], DIRECTED_WORDS[i][8]);
    end
    run_frames(220);

    drain();
    write_reg(tsfp_pkg::REG_HEADER, 16'hFFFF);
    write_reg(tsfp_pkg::REG_TAG, 16'h00FF);
    run_frames(250);

    drain();
    write_reg(tsfp_pkg::REG_HEADER, 16'h0000);
    write_reg(tsfp_pkg::REG_TAG, 16'h0000);
    run_frames(200);

    drain();
    write_reg(tsfp_pkg::REG_HEADER, 16'($urandom_range(0, 65535)));
    write_reg(tsfp_pkg::REG_TAG, 16'($urandom_range(0, 255)));
    run_frames(140);
    quiet = 1'b1;
    run_frames(140);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("tlv_sensor_frame_parser test passed");
    end else begin
      $display("tlv_sensor_frame_parser test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tlv_sensor_frame_parser test failed");
    $finish;
  end

endmodule
